### sv/spq_pkg.sv
// Shared types and codes for the stable priority queue.
// No dependencies.
package spq_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int NUM_PRIO = 10;
	localparam int PW = 4;

	localparam logic [PW-1:0] PRIO_MIN = 4'd1;
	localparam logic [PW-1:0] PRIO_MAX = 4'd10;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_PEEK   = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_FULL    = 2'd2,
		ST_BADPRIO = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_INS_FREE,
		S_INS_WR,
		S_RD
	} state_t;

endpackage

### sv/stable_priority_queue_top.sv
// Top level of the stable priority queue: per-priority linked lists in memory.
// Depends on spq_pkg.
//
// Usage: a request on the in channel (mode, value, priority_req) gives one
// result on the out channel (status, head_value, occupancy).
// Entries live in a value memory and a link memory; each of the ten
// priorities keeps head and tail pointers, and freed slots form a free list
// threaded through the link memory. Unused slots are handed out by a fill
// count, so no clearing pass is needed after reset.
// Path from request to result register: refused, empty or unused-mode
// requests load the result register directly; peek and remove pass through
// S_RD, inserts from never-used slots through S_INS_WR, and inserts that
// reuse a freed slot through S_INS_FREE (one link memory read) and S_INS_WR.
// One request is in work at a time; a new one is taken once it is through.
// Reset clears the queue to empty and drops any pending result.
// While out_stall holds a result, in_stall stays high and no request is
// taken until the result leaves.
module stable_priority_queue_top
	import spq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         mode,
	input  logic signed [31:0] value,
	input  logic [3:0]         priority_req,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [31:0] head_value,
	output logic [6:0]         occupancy
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = $clog2(NUM_PRIO);

	logic [31:0]   val_mem [CAPACITY];
	logic [IW-1:0] nxt_mem [CAPACITY];
	logic [31:0]   val_rd;
	logic [IW-1:0] nxt_rd;

	logic [IW-1:0] head_q [NUM_PRIO];
	logic [IW-1:0] tail_q [NUM_PRIO];
	logic [NUM_PRIO-1:0] nonempty_q;

	logic [CW-1:0] count_q, alloc_q, freecnt_q;
	logic [IW-1:0] free_head_q;

	state_t state_q, state_d;
	logic [1:0]    mode_q;
	logic [31:0]   value_q;
	logic [XW-1:0] idx_q;
	logic [IW-1:0] slot_q;

	logic          out_valid_q;
	logic [1:0]    status_q;
	logic [31:0]   head_out_q;
	logic [6:0]    occ_q;

	logic          accept;
	logic          prio_ok;
	logic          res_now;
	logic [XW-1:0] low_idx;
	logic [XW-1:0] ins_idx;
	logic          rd_en;
	logic [IW-1:0] rd_addr;

	assign in_stall   = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign accept     = in_valid && !in_stall;
	assign prio_ok    = (priority_req >= PRIO_MIN) && (priority_req <= PRIO_MAX);
	assign ins_idx    = XW'(priority_req - PRIO_MIN);
	assign res_now    = (state_q == S_INS_WR) || (state_q == S_RD) ||
		(accept && ((mode == MODE_INSERT) ? (!prio_ok || count_q == CW'(CAPACITY)) :
		(mode == MODE_NONE || count_q == '0)));
	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign head_value = head_out_q;
	assign occupancy  = occ_q;

	always_comb begin
		low_idx = '0;
		for (int i = NUM_PRIO - 1; i >= 0; i--) begin
			if (nonempty_q[i]) low_idx = XW'(i);
		end
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = head_q[low_idx];
		if (accept) begin
			unique case (mode_t'(mode))
				MODE_INSERT: begin
					rd_addr = free_head_q;
					rd_en = prio_ok && (count_q != CW'(CAPACITY)) && (freecnt_q != '0);
				end
				MODE_REMOVE, MODE_PEEK: rd_en = (count_q != '0);
				default: rd_en = 1'b0;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (mode_t'(mode))
						MODE_INSERT: begin
							if (prio_ok && (count_q != CW'(CAPACITY)))
								state_d = (freecnt_q != '0) ? S_INS_FREE : S_INS_WR;
						end
						MODE_REMOVE, MODE_PEEK: if (count_q != '0) state_d = S_RD;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_INS_FREE: state_d = S_INS_WR;
			S_INS_WR:   state_d = S_IDLE;
			S_RD:       state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			val_rd <= val_mem[rd_addr];
			nxt_rd <= nxt_mem[rd_addr];
		end
		if (state_q == S_INS_WR) begin
			val_mem[slot_q] <= value_q;
			if (nonempty_q[idx_q]) nxt_mem[tail_q[idx_q]] <= slot_q;
		end
		if (state_q == S_RD && mode_q == MODE_REMOVE) nxt_mem[slot_q] <= free_head_q;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= mode;
			value_q <= value;
			if (mode == MODE_INSERT) begin
				idx_q  <= ins_idx;
				slot_q <= (freecnt_q != '0) ? free_head_q : IW'(alloc_q);
			end else begin
				idx_q  <= low_idx;
				slot_q <= head_q[low_idx];
			end
		end
		if (state_q == S_INS_WR) begin
			tail_q[idx_q] <= slot_q;
			if (!nonempty_q[idx_q]) head_q[idx_q] <= slot_q;
		end
		if (state_q == S_RD && mode_q == MODE_REMOVE && head_q[idx_q] != tail_q[idx_q])
			head_q[idx_q] <= nxt_rd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			nonempty_q  <= '0;
			count_q     <= '0;
			alloc_q     <= '0;
			freecnt_q   <= '0;
			free_head_q <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			head_out_q  <= '0;
			occ_q       <= '0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= res_now || (out_valid_q && out_stall);
			if (accept) begin
				if (mode == MODE_INSERT) begin
					if (!prio_ok) begin
						status_q    <= ST_BADPRIO;
						head_out_q  <= '0;
						occ_q       <= 7'(count_q);
					end else if (count_q == CW'(CAPACITY)) begin
						status_q    <= ST_FULL;
						head_out_q  <= '0;
						occ_q       <= 7'(count_q);
					end else if (freecnt_q == '0) begin
						alloc_q <= alloc_q + 1'b1;
					end
				end else if (mode == MODE_NONE || count_q == '0) begin
					status_q    <= (mode == MODE_NONE) ? ST_OK : ST_EMPTY;
					head_out_q  <= '0;
					occ_q       <= 7'(count_q);
				end
			end
			unique case (state_q)
				S_INS_FREE: begin
					free_head_q <= nxt_rd;
					freecnt_q   <= freecnt_q - 1'b1;
				end
				S_INS_WR: begin
					nonempty_q[idx_q] <= 1'b1;
					count_q     <= count_q + 1'b1;
					status_q    <= ST_OK;
					head_out_q  <= '0;
					occ_q       <= 7'(count_q + 1'b1);
				end
				S_RD: begin
					status_q    <= ST_OK;
					head_out_q  <= val_rd;
					if (mode_q == MODE_REMOVE) begin
						if (head_q[idx_q] == tail_q[idx_q]) nonempty_q[idx_q] <= 1'b0;
						free_head_q <= slot_q;
						freecnt_q   <= freecnt_q + 1'b1;
						count_q     <= count_q - 1'b1;
						occ_q       <= 7'(count_q - 1'b1);
					end else begin
						occ_q       <= 7'(count_q);
					end
				end
				default: ;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY)) else $error("occupancy above capacity");
	a_slot_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (alloc_q == count_q + freecnt_q))
		else $error("slot accounting broken");
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall) else $error("request taken while busy");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_WR || state_q == S_RD) |-> !out_valid_q || !out_stall)
		else $error("result would overwrite a held result");

endmodule
